// ===== hw/rtl/ordc_pkg.sv =====
// ordc_pkg: shared constants, types and step functions for the oriented
// rectangle contact direction block
// no dependencies
package ordc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_DEPTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_COS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_SIN    = 3'd6;

  localparam logic [15:0] YAW_COS_RESET = 16'sd16384;

  localparam logic [1:0] CMD_CHECK = 2'd0;
  localparam logic [1:0] CMD_PUSH  = 2'd1;
  localparam logic [1:0] CMD_PULL  = 2'd2;

  localparam logic [32:0] HEIGHT_TOL = 33'd655;
  localparam int SECT_BITS  = 13;
  localparam int NORM_BITS  = 30;
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 16;
  localparam int FRONT_STAGES = 11;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] r;
  } sq_t;

  // per-request flags and scaled offsets carried down the pipe
  typedef struct packed {
    logic [1:0]  cmd;
    logic        ins;
    logic        upos;
    logic        wpos;
    logic        dxpos;
    logic        dypos;
    logic        dzpos;
    logic [29:0] nx;
    logic [29:0] ny;
    logic [29:0] nz;
  } ctl_t;

  typedef struct packed {
    logic               ins;
    logic               diag;
    logic               dxpos;
    logic               dypos;
    logic               dzpos;
    logic signed [16:0] ox;
    logic signed [16:0] oz;
    logic [29:0]        nx;
    logic [29:0]        ny;
    logic [29:0]        nz;
  } meta_t;

  // fewest right shifts that bring v under 2^bits
  function automatic logic [5:0] fit_shift(input logic [48:0] v, input int bits);
    logic [5:0] k;
    k = '0;
    for (int i = 0; i < 49; i++) begin
      if ((v >> i) >= (49'd1 << bits)) k = 6'(i + 1);
    end
    return k;
  endfunction

  function automatic sq_t sqrt_step(input sq_t s, input int i);
    logic [63:0] bit_v;
    sq_t o;
    bit_v = 64'd1 << (2 * i);
    o = s;
    if (s.x >= s.r + bit_v) begin
      o.x = s.x - (s.r + bit_v);
      o.r = (s.r >> 1) + bit_v;
    end else begin
      o.r = s.r >> 1;
    end
    return o;
  endfunction

endpackage

// ===== hw/rtl/ordc_if.sv =====
// ordc_if: request and result channel interfaces
// depends on nothing
interface ordc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] margin_x;
  logic signed [31:0] margin_z;
  modport source(output valid, cmd, pos_x, pos_y, pos_z, margin_x, margin_z, input ready);
  modport sink(input valid, cmd, pos_x, pos_y, pos_z, margin_x, margin_z, output ready);
endinterface

interface ordc_out_if;
  logic               valid;
  logic               ready;
  logic               inside_res;
  logic signed [16:0] dir_x;
  logic signed [16:0] dir_y;
  logic signed [16:0] dir_z;
  modport source(output valid, inside_res, dir_x, dir_y, dir_z, input ready);
  modport sink(input valid, inside_res, dir_x, dir_y, dir_z, output ready);
endinterface

// ===== hw/rtl/ordc_norm.sv =====
// ordc_norm: pipelined square root and three dividers for the unit
// centre-to-point vector; uses ordc_pkg
module ordc_norm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 v_in,
  input  logic [61:0]          sumsq,
  input  ordc_pkg::meta_t      meta_in,
  output logic                 v_out,
  output logic [15:0]          q_x,
  output logic [15:0]          q_y,
  output logic [15:0]          q_z,
  output logic                 len_zero,
  output ordc_pkg::meta_t      meta_out
);

  localparam int NS = ordc_pkg::SQRT_STEPS;
  localparam int ND = ordc_pkg::DIV_STEPS;

  ordc_pkg::sq_t   sq_r [NS];
  ordc_pkg::meta_t sm_r [NS];
  logic [NS-1:0]   sv_r;

  logic [47:0]     rx_r [ND];
  logic [47:0]     ry_r [ND];
  logic [47:0]     rz_r [ND];
  logic [15:0]     qx_r [ND];
  logic [15:0]     qy_r [ND];
  logic [15:0]     qz_r [ND];
  logic [30:0]     len_r [ND];
  ordc_pkg::meta_t dm_r [ND];
  logic [ND-1:0]   dv_r;

  // one root bit per stage, msb first
  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    ordc_pkg::sq_t   prev;
    ordc_pkg::meta_t pmeta;
    logic            pv;
    if (j == 0) begin : g_first
      assign prev  = '{x: 64'(sumsq), r: 64'd0};
      assign pmeta = meta_in;
      assign pv    = v_in;
    end else begin : g_next
      assign prev  = sq_r[j-1];
      assign pmeta = sm_r[j-1];
      assign pv    = sv_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[j] <= 1'b0;
      end else if (en) begin
        sv_r[j] <= pv;
      end
      if (en) begin
        sq_r[j] <= ordc_pkg::sqrt_step(prev, NS - 1 - j);
        sm_r[j] <= pmeta;
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < ND; k++) begin : g_div
    localparam int B = ND - 1 - k;
    logic [47:0]     px, py, pz;
    logic [15:0]     pqx, pqy, pqz;
    logic [30:0]     plen;
    ordc_pkg::meta_t pmeta;
    logic            pv;
    logic [47:0]     dsub;
    if (k == 0) begin : g_first
      assign plen  = sq_r[NS-1].r[30:0];
      assign pmeta = sm_r[NS-1];
      assign pv    = sv_r[NS-1];
      assign px    = {3'b0, sm_r[NS-1].nx, 15'b0};
      assign py    = {3'b0, sm_r[NS-1].ny, 15'b0};
      assign pz    = {3'b0, sm_r[NS-1].nz, 15'b0};
      assign pqx   = '0;
      assign pqy   = '0;
      assign pqz   = '0;
    end else begin : g_next
      assign plen  = len_r[k-1];
      assign pmeta = dm_r[k-1];
      assign pv    = dv_r[k-1];
      assign px    = rx_r[k-1];
      assign py    = ry_r[k-1];
      assign pz    = rz_r[k-1];
      assign pqx   = qx_r[k-1];
      assign pqy   = qy_r[k-1];
      assign pqz   = qz_r[k-1];
    end
    assign dsub = {17'b0, plen} << B;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (en) begin
        dv_r[k] <= pv;
      end
      if (en) begin
        len_r[k] <= plen;
        dm_r[k]  <= pmeta;
        rx_r[k]  <= (px >= dsub) ? px - dsub : px;
        ry_r[k]  <= (py >= dsub) ? py - dsub : py;
        rz_r[k]  <= (pz >= dsub) ? pz - dsub : pz;
        qx_r[k]  <= pqx | ((px >= dsub) ? (16'd1 << B) : 16'd0);
        qy_r[k]  <= pqy | ((py >= dsub) ? (16'd1 << B) : 16'd0);
        qz_r[k]  <= pqz | ((pz >= dsub) ? (16'd1 << B) : 16'd0);
      end
    end
  end

  assign v_out    = dv_r[ND-1];
  assign q_x      = qx_r[ND-1];
  assign q_y      = qy_r[ND-1];
  assign q_z      = qz_r[ND-1];
  assign len_zero = (len_r[ND-1] == '0);
  assign meta_out = dm_r[ND-1];

endmodule

// ===== hw/rtl/oriented_rect_contact_direction.sv =====
// oriented_rect_contact_direction: top level, point test against a yaw-rotated
// rectangle with push and pull directions; uses ordc_pkg, ordc_if, ordc_norm
//
// Requests arrive on in_chan (cmd, point, margins) and results leave on
// out_chan (inside flag and a direction, Q2.14 for push and pull, Q1.15 for
// a diagonal pull), one result per request, in order. Both channels move an
// item when valid and ready are high. Configuration is written through
// cfg_we/cfg_idx/cfg_wdata, one register per cycle; the user must write it
// only while no request is in flight, as the block itself does not enforce
// this. The pipe runs through stages of offset, rotation, scaling and sector
// test, then square root stages (one root bit each), division stages (one
// quotient bit each) and the output register. A request can be taken every
// cycle unless out_chan stalls. The whole pipe advances when the output
// register is empty or being taken; in_chan.ready follows that, so a stall at
// out_chan freezes every stage and nothing is lost or repeated.
// Reset (rst_n low at a clock edge) clears all valid bits and loads the
// register reset values: centre and extents zero, heading cosine one.
module oriented_rect_contact_direction (
  input  logic                             clk,
  input  logic                             rst_n,
  ordc_in_if.sink                          in_chan,
  ordc_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [ordc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ordc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // configuration registers
  logic signed [31:0] cx_r, cy_r, cz_r, hw_r, hd_r;
  logic signed [15:0] yc_r, ys_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      cz_r <= '0;
      hw_r <= '0;
      hd_r <= '0;
      yc_r <= ordc_pkg::YAW_COS_RESET;
      ys_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ordc_pkg::REG_CENTER_X:   cx_r <= cfg_wdata;
        ordc_pkg::REG_CENTER_Y:   cy_r <= cfg_wdata;
        ordc_pkg::REG_CENTER_Z:   cz_r <= cfg_wdata;
        ordc_pkg::REG_HALF_WIDTH: hw_r <= cfg_wdata;
        ordc_pkg::REG_HALF_DEPTH: hd_r <= cfg_wdata;
        ordc_pkg::REG_YAW_COS:    yc_r <= cfg_wdata[15:0];
        ordc_pkg::REG_YAW_SIN:    ys_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  logic [ordc_pkg::FRONT_STAGES-1:0] fv_r;

  assign en = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (en) begin
      fv_r <= {fv_r[ordc_pkg::FRONT_STAGES-2:0], in_chan.valid};
    end
  end

  // stage a: offsets and shrunk extents
  logic signed [32:0] a_dx_r, a_dy_r, a_dz_r, a_ex_r, a_ez_r;
  logic [1:0]         a_cmd_r;
  // stage b: rotation products
  logic signed [48:0] b_cdx_r, b_sdz_r, b_sdx_r, b_cdz_r;
  logic signed [32:0] b_dx_r, b_dy_r, b_dz_r, b_ex_r, b_ez_r;
  logic [1:0]         b_cmd_r;
  // stage c: local frame coordinates
  logic signed [49:0] c_u_r, c_w_r;
  logic signed [32:0] c_dx_r, c_dy_r, c_dz_r, c_ex_r, c_ez_r;
  logic [1:0]         c_cmd_r;
  // stage d: magnitudes and signs
  logic [48:0]        d_mu_r, d_mw_r;
  logic [46:0]        d_mh_r;
  logic [32:0]        d_mex_r, d_mez_r, d_ax_r, d_ay_r, d_az_r;
  logic               d_upos_r, d_wpos_r, d_dxpos_r, d_dypos_r, d_dzpos_r;
  logic [1:0]         d_cmd_r;
  // stage e: containment and scaling shifts
  logic [48:0]        e_mu_r, e_mw_r;
  logic [46:0]        e_mh_r;
  logic [32:0]        e_mex_r, e_mez_r, e_ax_r, e_ay_r, e_az_r;
  logic [4:0]         e_ke_r;
  logic [5:0]         e_kd_r;
  logic [1:0]         e_kn_r;
  ordc_pkg::ctl_t     e_ctl_r;
  // stage f: scaled values
  logic [12:0]        f_sex_r, f_sez_r, f_su_r, f_sw_r, f_sh_r;
  ordc_pkg::ctl_t     f_ctl_r;
  // stage g: squares
  logic [25:0]        g_ex2_r, g_ez2_r, g_u2_r, g_w2_r, g_h2_r;
  logic [59:0]        g_nx2_r, g_ny2_r, g_nz2_r;
  ordc_pkg::ctl_t     g_ctl_r;
  // stage h: first products and sums
  logic [51:0]        h_t1_r, h_t2_r;
  logic signed [26:0] h_dif_r;
  logic [26:0]        h_se_r;
  logic [27:0]        h_sd_r;
  logic [25:0]        h_h2_r;
  logic [61:0]        h_sumsq_r;
  ordc_pkg::ctl_t     h_ctl_r;
  // stage i: second products
  logic [51:0]        i_t1_r, i_t2_r;
  logic signed [53:0] i_t3_r;
  logic [54:0]        i_dd_r;
  logic [61:0]        i_sumsq_r;
  ordc_pkg::ctl_t     i_ctl_r;
  // stage j: sector numerator
  logic signed [55:0] j_n_r;
  logic [54:0]        j_dd_r;
  logic [61:0]        j_sumsq_r;
  ordc_pkg::ctl_t     j_ctl_r;
  // stage k: direction choice
  ordc_pkg::meta_t    k_meta_r;
  logic [61:0]        k_sumsq_r;

  logic signed [49:0] u_abs_src, w_abs_src;
  logic signed [32:0] dy_abs_src;
  logic [32:0]        maxe;
  logic [48:0]        maxd;
  logic [32:0]        maxn;
  logic signed [16:0] c17, s17;
  logic signed [55:0] n_eff;
  logic signed [63:0] n100, dd64;
  logic signed [16:0] k_ox, k_oz;
  logic               k_diag;

  assign u_abs_src  = c_u_r[49] ? -c_u_r : c_u_r;
  assign w_abs_src  = c_w_r[49] ? -c_w_r : c_w_r;
  assign dy_abs_src = c_dy_r[32] ? -c_dy_r : c_dy_r;

  always_comb begin
    maxe = (d_mex_r > d_mez_r) ? d_mex_r : d_mez_r;
    maxd = (d_mu_r > d_mw_r) ? d_mu_r : d_mw_r;
    if ({2'b0, d_mh_r} > maxd) maxd = {2'b0, d_mh_r};
    maxn = (d_ax_r > d_ay_r) ? d_ax_r : d_ay_r;
    if (d_az_r > maxn) maxn = d_az_r;
  end

  assign c17 = {yc_r[15], yc_r};
  assign s17 = {ys_r[15], ys_r};

  // empty rectangle or point at centre counts as no sector preference
  assign n_eff = (j_dd_r == '0) ? 56'sd0 : j_n_r;
  assign n100  = 64'(n_eff) * 64'sd100;
  assign dd64  = $signed({9'b0, j_dd_r});

  always_comb begin
    k_ox   = '0;
    k_oz   = '0;
    k_diag = 1'b0;
    if (j_ctl_r.cmd == ordc_pkg::CMD_PUSH && j_ctl_r.ins) begin
      if (n_eff < 0) begin
        k_ox = j_ctl_r.wpos ? s17 : -s17;
        k_oz = j_ctl_r.wpos ? c17 : -c17;
      end else begin
        k_ox = j_ctl_r.upos ? c17 : -c17;
        k_oz = j_ctl_r.upos ? -s17 : s17;
      end
    end else if (j_ctl_r.cmd == ordc_pkg::CMD_PULL && !j_ctl_r.ins) begin
      if (j_dd_r != '0 && n100 < -dd64) begin
        k_ox = j_ctl_r.wpos ? -s17 : s17;
        k_oz = j_ctl_r.wpos ? -c17 : c17;
      end else if (j_dd_r != '0 && n100 > dd64) begin
        k_ox = j_ctl_r.upos ? -c17 : c17;
        k_oz = j_ctl_r.upos ? s17 : -s17;
      end else begin
        k_diag = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx_r  <= $signed({in_chan.pos_x[31], in_chan.pos_x}) - $signed({cx_r[31], cx_r});
      a_dy_r  <= $signed({in_chan.pos_y[31], in_chan.pos_y}) - $signed({cy_r[31], cy_r});
      a_dz_r  <= $signed({in_chan.pos_z[31], in_chan.pos_z}) - $signed({cz_r[31], cz_r});
      a_ex_r  <= $signed({hw_r[31], hw_r}) - $signed({in_chan.margin_x[31], in_chan.margin_x});
      a_ez_r  <= $signed({hd_r[31], hd_r}) - $signed({in_chan.margin_z[31], in_chan.margin_z});
      a_cmd_r <= in_chan.cmd;

      b_cdx_r <= 49'(yc_r) * 49'(a_dx_r);
      b_sdz_r <= 49'(ys_r) * 49'(a_dz_r);
      b_sdx_r <= 49'(ys_r) * 49'(a_dx_r);
      b_cdz_r <= 49'(yc_r) * 49'(a_dz_r);
      b_dx_r  <= a_dx_r;
      b_dy_r  <= a_dy_r;
      b_dz_r  <= a_dz_r;
      b_ex_r  <= a_ex_r;
      b_ez_r  <= a_ez_r;
      b_cmd_r <= a_cmd_r;

      c_u_r   <= 50'(b_cdx_r) - 50'(b_sdz_r);
      c_w_r   <= 50'(b_sdx_r) + 50'(b_cdz_r);
      c_dx_r  <= b_dx_r;
      c_dy_r  <= b_dy_r;
      c_dz_r  <= b_dz_r;
      c_ex_r  <= b_ex_r;
      c_ez_r  <= b_ez_r;
      c_cmd_r <= b_cmd_r;

      d_mu_r    <= u_abs_src[48:0];
      d_mw_r    <= w_abs_src[48:0];
      d_mh_r    <= {dy_abs_src, 14'b0};
      d_ay_r    <= dy_abs_src;
      d_ax_r    <= c_dx_r[32] ? -c_dx_r : c_dx_r;
      d_az_r    <= c_dz_r[32] ? -c_dz_r : c_dz_r;
      d_mex_r   <= c_ex_r[32] ? -c_ex_r : c_ex_r;
      d_mez_r   <= c_ez_r[32] ? -c_ez_r : c_ez_r;
      d_upos_r  <= !c_u_r[49] && (c_u_r != '0);
      d_wpos_r  <= !c_w_r[49] && (c_w_r != '0);
      d_dxpos_r <= !c_dx_r[32] && (c_dx_r != '0);
      d_dypos_r <= !c_dy_r[32] && (c_dy_r != '0);
      d_dzpos_r <= !c_dz_r[32] && (c_dz_r != '0);
      d_cmd_r   <= c_cmd_r;

      e_mu_r  <= d_mu_r;
      e_mw_r  <= d_mw_r;
      e_mh_r  <= d_mh_r;
      e_mex_r <= d_mex_r;
      e_mez_r <= d_mez_r;
      e_ax_r  <= d_ax_r;
      e_ay_r  <= d_ay_r;
      e_az_r  <= d_az_r;
      e_ke_r  <= 5'(ordc_pkg::fit_shift(49'(maxe), ordc_pkg::SECT_BITS));
      e_kd_r  <= ordc_pkg::fit_shift(maxd, ordc_pkg::SECT_BITS);
      e_kn_r  <= 2'(ordc_pkg::fit_shift(49'(maxn), ordc_pkg::NORM_BITS));
      e_ctl_r.cmd    <= d_cmd_r;
      e_ctl_r.ins    <= (d_mu_r < {2'b0, d_mex_r, 14'b0}) &&
                        (d_mw_r < {2'b0, d_mez_r, 14'b0}) &&
                        (d_ay_r <= ordc_pkg::HEIGHT_TOL);
      e_ctl_r.upos   <= d_upos_r;
      e_ctl_r.wpos   <= d_wpos_r;
      e_ctl_r.dxpos  <= d_dxpos_r;
      e_ctl_r.dypos  <= d_dypos_r;
      e_ctl_r.dzpos  <= d_dzpos_r;
      e_ctl_r.nx     <= '0;
      e_ctl_r.ny     <= '0;
      e_ctl_r.nz     <= '0;

      f_sex_r <= 13'(e_mex_r >> e_ke_r);
      f_sez_r <= 13'(e_mez_r >> e_ke_r);
      f_su_r  <= 13'(e_mu_r >> e_kd_r);
      f_sw_r  <= 13'(e_mw_r >> e_kd_r);
      f_sh_r  <= 13'(e_mh_r >> e_kd_r);
      f_ctl_r <= '{cmd: e_ctl_r.cmd, ins: e_ctl_r.ins, upos: e_ctl_r.upos,
                   wpos: e_ctl_r.wpos, dxpos: e_ctl_r.dxpos, dypos: e_ctl_r.dypos,
                   dzpos: e_ctl_r.dzpos,
                   nx: 30'(e_ax_r >> e_kn_r),
                   ny: 30'(e_ay_r >> e_kn_r),
                   nz: 30'(e_az_r >> e_kn_r)};

      g_ex2_r <= f_sex_r * f_sex_r;
      g_ez2_r <= f_sez_r * f_sez_r;
      g_u2_r  <= f_su_r * f_su_r;
      g_w2_r  <= f_sw_r * f_sw_r;
      g_h2_r  <= f_sh_r * f_sh_r;
      g_nx2_r <= f_ctl_r.nx * f_ctl_r.nx;
      g_ny2_r <= f_ctl_r.ny * f_ctl_r.ny;
      g_nz2_r <= f_ctl_r.nz * f_ctl_r.nz;
      g_ctl_r <= f_ctl_r;

      h_t1_r    <= g_ez2_r * g_u2_r;
      h_t2_r    <= g_ex2_r * g_w2_r;
      h_dif_r   <= $signed({1'b0, g_ez2_r}) - $signed({1'b0, g_ex2_r});
      h_se_r    <= 27'(g_ex2_r) + 27'(g_ez2_r);
      h_sd_r    <= 28'(g_u2_r) + 28'(g_w2_r) + 28'(g_h2_r);
      h_h2_r    <= g_h2_r;
      h_sumsq_r <= 62'(g_nx2_r) + 62'(g_ny2_r) + 62'(g_nz2_r);
      h_ctl_r   <= g_ctl_r;

      i_t1_r    <= h_t1_r;
      i_t2_r    <= h_t2_r;
      i_t3_r    <= h_dif_r * $signed({1'b0, h_h2_r});
      i_dd_r    <= h_se_r * h_sd_r;
      i_sumsq_r <= h_sumsq_r;
      i_ctl_r   <= h_ctl_r;

      j_n_r     <= $signed({4'b0, i_t1_r}) - $signed({4'b0, i_t2_r}) + 56'(i_t3_r);
      j_dd_r    <= i_dd_r;
      j_sumsq_r <= i_sumsq_r;
      j_ctl_r   <= i_ctl_r;

      k_meta_r.ins    <= j_ctl_r.ins;
      k_meta_r.diag   <= k_diag;
      k_meta_r.dxpos  <= j_ctl_r.dxpos;
      k_meta_r.dypos  <= j_ctl_r.dypos;
      k_meta_r.dzpos  <= j_ctl_r.dzpos;
      k_meta_r.ox     <= k_ox;
      k_meta_r.oz     <= k_oz;
      k_meta_r.nx     <= j_ctl_r.nx;
      k_meta_r.ny     <= j_ctl_r.ny;
      k_meta_r.nz     <= j_ctl_r.nz;
      k_sumsq_r       <= j_sumsq_r;
    end
  end

  logic               nv;
  logic [15:0]        qx, qy, qz;
  logic               len_zero;
  ordc_pkg::meta_t    nmeta;

  ordc_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (fv_r[ordc_pkg::FRONT_STAGES-1]),
    .sumsq    (k_sumsq_r),
    .meta_in  (k_meta_r),
    .v_out    (nv),
    .q_x      (qx),
    .q_y      (qy),
    .q_z      (qz),
    .len_zero (len_zero),
    .meta_out (nmeta)
  );

  logic signed [16:0] fin_x, fin_y, fin_z;
  logic signed [16:0] qx17, qy17, qz17;
  logic               inside_r;
  logic signed [16:0] dir_x_r, dir_y_r, dir_z_r;

  assign qx17 = $signed({1'b0, qx});
  assign qy17 = $signed({1'b0, qy});
  assign qz17 = $signed({1'b0, qz});

  always_comb begin
    fin_x = nmeta.ox;
    fin_y = '0;
    fin_z = nmeta.oz;
    if (nmeta.diag) begin
      if (len_zero) begin
        fin_x = '0;
        fin_z = '0;
      end else begin
        fin_x = nmeta.dxpos ? -qx17 : qx17;
        fin_y = nmeta.dypos ? -qy17 : qy17;
        fin_z = nmeta.dzpos ? -qz17 : qz17;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= nv;
    end
    if (en) begin
      inside_r <= nmeta.ins;
      dir_x_r  <= fin_x;
      dir_y_r  <= fin_y;
      dir_z_r  <= fin_z;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.inside_res = inside_r;
  assign out_chan.dir_x      = dir_x_r;
  assign out_chan.dir_y      = dir_y_r;
  assign out_chan.dir_z      = dir_z_r;

  // an inside point never gets a vertical component
  a_inside_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.inside_res |-> out_chan.dir_y == '0)
    else $error("inside result with vertical direction");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> fv_r[0])
    else $error("accepted request missing from first stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid && fv_r == '0)
    else $error("pipeline not empty after reset");

endmodule
